/* rtl/pixel_subsample_format_converter_defines.svh */
// Assertion macros shared by the pixel converter RTL.
`ifndef PIXEL_SUBSAMPLE_FORMAT_CONVERTER_DEFINES_SVH
`define PIXEL_SUBSAMPLE_FORMAT_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define PSFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pixel converter check failed");

// Next-cycle implication.
`define PSFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pixel converter check failed");

`endif

/* rtl/psfc_pkg.sv */
// Package with types and constants for the pixel subsample format converter.
`timescale 1ns / 1ps
package psfc_pkg;

   // Fixed widths of the pixel fields
   localparam int CoordWidth = 16;
   localparam int ChanWidth  = 8;
   localparam int WordWidth  = 32;

   // Restoring divider: one quotient bit per stage
   localparam int DivStages = CoordWidth;

   // Luminance weights
   localparam logic [7:0] LumaRed   = 8'd77;
   localparam logic [7:0] LumaGreen = 8'd150;
   localparam logic [7:0] LumaBlue  = 8'd29;
   localparam logic [7:0] ChanFull  = 8'hFF;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_REGION_X      = 3'd0,
      CSR_REGION_Y      = 3'd1,
      CSR_REGION_WIDTH  = 3'd2,
      CSR_REGION_HEIGHT = 3'd3,
      CSR_SAMPLE_FACTOR = 3'd4,
      CSR_SOURCE_FORMAT = 3'd5,
      CSR_DEST_FORMAT   = 3'd6,
      CSR_OPTION_FLAGS  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_BILEVEL = 2'd0,
      SRC_GRAY8   = 2'd1,
      SRC_RGB8    = 2'd2,
      SRC_RGBA    = 2'd3
   } src_format_type;

   typedef enum logic [1:0] {
      DST_RGBA8888 = 2'd0,
      DST_RGB565   = 2'd1,
      DST_ALPHA8   = 2'd2
   } dst_format_type;

   // Option flag bit positions
   localparam int OptSwapBit     = 0;
   localparam int OptMinWhiteBit = 1;
   localparam int OptMsbFirstBit = 2;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] alpha;
   } pixel_type;

   // Pixel and range flag that ride alongside the divider
   typedef struct packed {
      logic      in_range;
      pixel_type pix;
   } carry_type;

   // Result of the front stage
   typedef struct packed {
      logic [CoordWidth-1:0] off_x;
      logic [CoordWidth-1:0] off_y;
      carry_type             carry;
   } front_type;

endpackage

/* rtl/psfc_front.sv */
// Front stage: region offsets, range check and expansion to r,g,b,a.
`timescale 1ns / 1ps
module psfc_front (
   input  logic                             clock,
   input  logic                             en,
   input  logic [psfc_pkg::CoordWidth-1:0]  src_col,
   input  logic [psfc_pkg::CoordWidth-1:0]  src_row,
   input  psfc_pkg::pixel_type              chan_in,
   input  logic [psfc_pkg::CoordWidth-1:0]  region_x,
   input  logic [psfc_pkg::CoordWidth-1:0]  region_y,
   input  logic [psfc_pkg::CoordWidth-1:0]  region_width,
   input  logic [psfc_pkg::CoordWidth-1:0]  region_height,
   input  psfc_pkg::src_format_type         source_format,
   input  logic                             alpha8,
   input  logic [2:0]                       option_flags,
   output psfc_pkg::front_type              front_ff
);
   import psfc_pkg::*;

   front_type             front_in;
   logic [CoordWidth:0]   diff_x;
   logic [CoordWidth:0]   diff_y;
   logic [2:0]            bit_sel;
   logic                  bit_one;
   logic                  black;
   logic                  min_white;
   logic [ChanWidth-1:0]  gray;
   logic [15:0]           luma_sum;

   always_comb begin
      // offsets with borrow as sign
      diff_x = {1'b0, src_col} - {1'b0, region_x};
      diff_y = {1'b0, src_row} - {1'b0, region_y};
      min_white = option_flags[OptMinWhiteBit];

      // bilevel bit pick
      bit_sel = src_col[2:0];
      if (option_flags[OptMsbFirstBit]) begin
         bit_one = chan_in.red[3'd7 - bit_sel];
      end else begin
         bit_one = chan_in.red[bit_sel];
      end
      black = min_white ? bit_one : !bit_one;

      gray = min_white ? (ChanFull - chan_in.red) : chan_in.red;

      // luminance on the unswapped channels
      luma_sum = 16'(chan_in.red) * 16'(LumaRed) + 16'(chan_in.green) * 16'(LumaGreen)
               + 16'(chan_in.blue) * 16'(LumaBlue);

      front_in.off_x = diff_x[CoordWidth-1:0];
      front_in.off_y = diff_y[CoordWidth-1:0];
      front_in.carry.in_range = !diff_x[CoordWidth] && !diff_y[CoordWidth]
                              && (diff_x[CoordWidth-1:0] < region_width)
                              && (diff_y[CoordWidth-1:0] < region_height);

      unique case (source_format)
         SRC_BILEVEL: begin
            if (alpha8) begin
               front_in.carry.pix = '{red: '0, green: '0, blue: '0,
                                      alpha: black ? ChanFull : '0};
            end else if (black) begin
               front_in.carry.pix = '{red: '0, green: '0, blue: '0, alpha: ChanFull};
            end else begin
               front_in.carry.pix = '{red: ChanFull, green: ChanFull, blue: ChanFull,
                                      alpha: ChanFull};
            end
         end
         SRC_GRAY8: begin
            front_in.carry.pix = '{red: gray, green: gray, blue: gray,
                                   alpha: alpha8 ? gray : ChanFull};
         end
         SRC_RGB8: begin
            front_in.carry.pix = '{red: chan_in.red, green: chan_in.green,
                                   blue: chan_in.blue,
                                   alpha: alpha8 ? luma_sum[15:8] : ChanFull};
         end
         SRC_RGBA: begin
            front_in.carry.pix = chan_in;
         end
         default: begin
            front_in.carry.pix = chan_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

endmodule

/* rtl/psfc_div_stage.sv */
// One restoring division step: develops one quotient bit per stage.
`timescale 1ns / 1ps
module psfc_div_stage (
   input  logic                             clock,
   input  logic                             en,
   input  logic [psfc_pkg::CoordWidth-1:0]  divisor,
   input  logic [psfc_pkg::CoordWidth-1:0]  rem_prev,
   input  logic [psfc_pkg::CoordWidth-1:0]  work_prev,
   output logic [psfc_pkg::CoordWidth-1:0]  rem_ff,
   output logic [psfc_pkg::CoordWidth-1:0]  work_ff
);
   import psfc_pkg::*;

   logic [CoordWidth:0]   trial;
   logic [CoordWidth:0]   diff;
   logic                  fits;
   logic [CoordWidth-1:0] rem_in;
   logic [CoordWidth-1:0] work_in;

   // shift in next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_prev, work_prev[CoordWidth-1]};
      diff    = trial - {1'b0, divisor};
      fits    = trial >= {1'b0, divisor};
      rem_in  = fits ? diff[CoordWidth-1:0] : trial[CoordWidth-1:0];
      work_in = {work_prev[CoordWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

endmodule

/* rtl/psfc_pack.sv */
// Output stage: keep decision, red/blue swap and destination packing.
`timescale 1ns / 1ps
module psfc_pack #(
   parameter int COORD_BITS = 16
) (
   input  logic                             clock,
   input  logic                             en,
   input  psfc_pkg::carry_type              carry,
   input  logic [psfc_pkg::CoordWidth-1:0]  rem_col,
   input  logic [psfc_pkg::CoordWidth-1:0]  quo_col,
   input  logic [psfc_pkg::CoordWidth-1:0]  rem_row,
   input  logic [psfc_pkg::CoordWidth-1:0]  quo_row,
   input  logic [1:0]                       dest_format,
   input  logic                             swap_rb,
   output logic                             keep_ff,
   output logic [psfc_pkg::CoordWidth-1:0]  dst_col_ff,
   output logic [psfc_pkg::CoordWidth-1:0]  dst_row_ff,
   output logic [psfc_pkg::WordWidth-1:0]   pixel_word_ff
);
   import psfc_pkg::*;

   localparam int QuoBits = (COORD_BITS < CoordWidth) ? COORD_BITS : CoordWidth;

   logic                  keep_in;
   logic [CoordWidth-1:0] dst_col_in;
   logic [CoordWidth-1:0] dst_row_in;
   logic [WordWidth-1:0]  pixel_word_in;
   logic [ChanWidth-1:0]  red;
   logic [ChanWidth-1:0]  blue;
   logic [WordWidth-1:0]  word;

   always_comb begin
      red  = swap_rb ? carry.pix.blue : carry.pix.red;
      blue = swap_rb ? carry.pix.red  : carry.pix.blue;

      unique case (dest_format)
         DST_ALPHA8:   word = WordWidth'(carry.pix.alpha);
         DST_RGB565:   word = WordWidth'({red[7:3], carry.pix.green[7:2], blue[7:3]});
         DST_RGBA8888: word = {carry.pix.alpha, blue, carry.pix.green, red};
         default:      word = {carry.pix.alpha, blue, carry.pix.green, red};
      endcase

      // on the grid only when both remainders are zero
      keep_in = carry.in_range && (rem_col == '0) && (rem_row == '0);

      if (keep_in) begin
         dst_col_in    = CoordWidth'(quo_col[QuoBits-1:0]);
         dst_row_in    = CoordWidth'(quo_row[QuoBits-1:0]);
         pixel_word_in = word;
      end else begin
         dst_col_in    = '0;
         dst_row_in    = '0;
         pixel_word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         keep_ff       <= keep_in;
         dst_col_ff    <= dst_col_in;
         dst_row_ff    <= dst_row_in;
         pixel_word_ff <= pixel_word_in;
      end
   end

endmodule

/* rtl/pixel_subsample_format_converter.sv */
// Top level of the pixel subsample format converter.
`timescale 1ns / 1ps
// Crops, decimates and converts one pixel per clock while rsp is not stalled.
// Each accepted beat goes through a front stage (region offsets, range check,
// expansion to r,g,b,a), sixteen restoring-division stages that each develop
// one quotient bit of offset / sample_factor for both axes, and an output
// stage that decides keep and packs RGBA8888, RGB565 or ALPHA8. Throughput is
// one beat per cycle while rsp_tready is high. Bubbles close up when rsp
// stalls. Every accepted beat gives one rsp beat; rejected pixels come out
// with keep low and all data zero. The user must write configuration through
// the csr port only while no beat is in flight; the block does not enforce
// this. csr_ready is always high.
`include "pixel_subsample_format_converter_defines.svh"
module pixel_subsample_format_converter #(
   parameter int COORD_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: src_col[15:0], src_row[31:16], chan_red[39:32],
   //            chan_green[47:40], chan_blue[55:48], chan_alpha[63:56]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // rsp_tdata: dst_col[15:0], dst_row[31:16], pixel_word[63:32]
   // rsp_tuser: keep
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import psfc_pkg::*;

   localparam int NumStages = DivStages + 2;

   // configuration registers
   logic [CoordWidth-1:0] region_x_ff;
   logic [CoordWidth-1:0] region_y_ff;
   logic [CoordWidth-1:0] region_width_ff;
   logic [CoordWidth-1:0] region_height_ff;
   logic [CoordWidth-1:0] sample_factor_ff;
   src_format_type        source_format_ff;
   logic [1:0]            dest_format_ff;
   logic [2:0]            option_flags_ff;

   logic [CoordWidth-1:0] divisor;
   logic [NumStages-1:0]  valid_ff;
   logic [NumStages-1:0]  valid_in;
   logic [NumStages-1:0]  en;
   pixel_type             chan_in;
   front_type             front_ff;
   carry_type             carry_ff [DivStages];
   logic [CoordWidth-1:0] rem_x  [DivStages];
   logic [CoordWidth-1:0] work_x [DivStages];
   logic [CoordWidth-1:0] rem_y  [DivStages];
   logic [CoordWidth-1:0] work_y [DivStages];
   logic                  keep_ff;
   logic [CoordWidth-1:0] dst_col_ff;
   logic [CoordWidth-1:0] dst_row_ff;
   logic [WordWidth-1:0]  pixel_word_ff;

   assign csr_ready = 1'b1;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         region_x_ff      <= '0;
         region_y_ff      <= '0;
         region_width_ff  <= CoordWidth'(1);
         region_height_ff <= CoordWidth'(1);
         sample_factor_ff <= CoordWidth'(1);
         source_format_ff <= SRC_RGBA;
         dest_format_ff   <= DST_RGBA8888;
         option_flags_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REGION_X:      region_x_ff      <= csr_data;
            CSR_REGION_Y:      region_y_ff      <= csr_data;
            CSR_REGION_WIDTH:  region_width_ff  <= csr_data;
            CSR_REGION_HEIGHT: region_height_ff <= csr_data;
            CSR_SAMPLE_FACTOR: sample_factor_ff <= csr_data;
            CSR_SOURCE_FORMAT: source_format_ff <= src_format_type'(csr_data[1:0]);
            CSR_DEST_FORMAT:   dest_format_ff   <= csr_data[1:0];
            CSR_OPTION_FLAGS:  option_flags_ff  <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // a zero sample factor acts as one
   assign divisor = (sample_factor_ff == '0) ? CoordWidth'(1) : sample_factor_ff;

   // stage k moves when rsp_tready is high or it or some later stage has a hole
   always_comb begin
      for (int k = 0; k < NumStages; k++) begin
         en[k] = rsp_tready || (|((~valid_ff) >> k));
      end
      valid_in[0] = req_tvalid;
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NumStages-1];

   assign chan_in = '{red: req_tdata[39:32], green: req_tdata[47:40],
                      blue: req_tdata[55:48], alpha: req_tdata[63:56]};

   psfc_front u_front (
      .clock         (clock),
      .en            (en[0]),
      .src_col       (req_tdata[15:0]),
      .src_row       (req_tdata[31:16]),
      .chan_in       (chan_in),
      .region_x      (region_x_ff),
      .region_y      (region_y_ff),
      .region_width  (region_width_ff),
      .region_height (region_height_ff),
      .source_format (source_format_ff),
      .alpha8        (dest_format_ff == DST_ALPHA8),
      .option_flags  (option_flags_ff),
      .front_ff      (front_ff)
   );

   // divider pipeline, both axes side by side
   for (genvar s = 0; s < DivStages; s++) begin : g_div
      if (s == 0) begin : g_first
         psfc_div_stage u_div_x (
            .clock (clock), .en (en[1]), .divisor (divisor),
            .rem_prev ('0), .work_prev (front_ff.off_x),
            .rem_ff (rem_x[0]), .work_ff (work_x[0])
         );
         psfc_div_stage u_div_y (
            .clock (clock), .en (en[1]), .divisor (divisor),
            .rem_prev ('0), .work_prev (front_ff.off_y),
            .rem_ff (rem_y[0]), .work_ff (work_y[0])
         );
         always_ff @(posedge clock) begin
            if (en[1]) begin
               carry_ff[0] <= front_ff.carry;
            end
         end
      end else begin : g_next
         psfc_div_stage u_div_x (
            .clock (clock), .en (en[s+1]), .divisor (divisor),
            .rem_prev (rem_x[s-1]), .work_prev (work_x[s-1]),
            .rem_ff (rem_x[s]), .work_ff (work_x[s])
         );
         psfc_div_stage u_div_y (
            .clock (clock), .en (en[s+1]), .divisor (divisor),
            .rem_prev (rem_y[s-1]), .work_prev (work_y[s-1]),
            .rem_ff (rem_y[s]), .work_ff (work_y[s])
         );
         always_ff @(posedge clock) begin
            if (en[s+1]) begin
               carry_ff[s] <= carry_ff[s-1];
            end
         end
      end
   end

   psfc_pack #(
      .COORD_BITS (COORD_BITS)
   ) u_pack (
      .clock         (clock),
      .en            (en[NumStages-1]),
      .carry         (carry_ff[DivStages-1]),
      .rem_col       (rem_x[DivStages-1]),
      .quo_col       (work_x[DivStages-1]),
      .rem_row       (rem_y[DivStages-1]),
      .quo_row       (work_y[DivStages-1]),
      .dest_format   (dest_format_ff),
      .swap_rb       (option_flags_ff[OptSwapBit]),
      .keep_ff       (keep_ff),
      .dst_col_ff    (dst_col_ff),
      .dst_row_ff    (dst_row_ff),
      .pixel_word_ff (pixel_word_ff)
   );

   assign rsp_tdata = {pixel_word_ff, dst_row_ff, dst_col_ff};
   assign rsp_tuser = keep_ff;

   // checks
   `PSFC_ASSERT_NOW(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata == 64'd0)
   `PSFC_ASSERT_NOW(a_alpha8_narrow, clock, reset,
      rsp_tvalid && (dest_format_ff == DST_ALPHA8), rsp_tdata[63:40] == 24'd0)
   `PSFC_ASSERT_NOW(a_open_when_drained, clock, reset, !valid_ff[NumStages-1],
      req_tready)
   `PSFC_ASSERT_NEXT(a_stall_holds_keep, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(keep_ff))

endmodule
